FILE: rtl/core/tcpf_pkg.sv
// Shared types and constants for the TCP/ICMP header drop filter.
// No dependencies; imported by every module of the filter.
`timescale 1ns / 1ps

package tcpf_pkg;

    // Byte index within a frame, saturating at the top value
    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    // Byte offsets of captured header fields
    localparam logic [POS_W-1:0] OFS_ETYPE_HI  = 6'd12;
    localparam logic [POS_W-1:0] OFS_ETYPE_LO  = 6'd13;
    localparam logic [POS_W-1:0] OFS_FRAG_HI   = 6'd20;
    localparam logic [POS_W-1:0] OFS_FRAG_LO   = 6'd21;
    localparam logic [POS_W-1:0] OFS_PROTO     = 6'd23;
    localparam logic [POS_W-1:0] OFS_SRC_0     = 6'd26;
    localparam logic [POS_W-1:0] OFS_SRC_1     = 6'd27;
    localparam logic [POS_W-1:0] OFS_SRC_2     = 6'd28;
    localparam logic [POS_W-1:0] OFS_SRC_3     = 6'd29;
    localparam logic [POS_W-1:0] OFS_DST_0     = 6'd30;
    localparam logic [POS_W-1:0] OFS_DST_1     = 6'd31;
    localparam logic [POS_W-1:0] OFS_DST_2     = 6'd32;
    localparam logic [POS_W-1:0] OFS_DST_3     = 6'd33;
    localparam logic [POS_W-1:0] OFS_ICMP_TYPE = 6'd34;
    localparam logic [POS_W-1:0] OFS_ICMP_CODE = 6'd35;
    localparam logic [POS_W-1:0] OFS_TCP_DOFF  = 6'd46;
    localparam logic [POS_W-1:0] OFS_TCP_FLAGS = 6'd47;
    localparam logic [POS_W-1:0] OFS_WIN_HI    = 6'd48;
    localparam logic [POS_W-1:0] OFS_WIN_LO    = 6'd49;

    // Minimum last-byte index (length - 1) for each header to be complete
    localparam logic [POS_W-1:0] IDX_MIN_IPV4 = 6'd33;
    localparam logic [POS_W-1:0] IDX_MIN_ICMP = 6'd41;
    localparam logic [POS_W-1:0] IDX_MIN_TCP  = 6'd53;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
    localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;
    localparam logic [7:0]  ICMP_CODE_ZERO  = 8'd0;
    localparam logic [3:0]  DOFF_MIN    = 4'd5;
    localparam logic [15:0] FRAG_MASK   = 16'h3FFF;

    // TCP flag bit positions within the captured flag field
    localparam int unsigned FLAG_FIN = 0;
    localparam int unsigned FLAG_SYN = 1;
    localparam int unsigned FLAG_RST = 2;
    localparam int unsigned FLAG_PSH = 3;
    localparam int unsigned FLAG_ACK = 4;
    localparam int unsigned FLAG_URG = 5;
    localparam logic [5:0]  FLAGS_ACK_ONLY = 6'b01_0000;

    localparam int unsigned CNT_W = 32;

    // Captured header fields handed to the verdict stage
    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] fragment_field;
        logic        addresses_equal;
        logic [5:0]  flag_bits;
        logic [3:0]  header_words;
        logic [15:0] window_size;
        logic [7:0]  icmp_kind;
        logic [7:0]  icmp_subcode;
    } hdr_fields_t;

    // End-of-frame event from the capture stage
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] last_idx;
    } frame_evt_t;

endpackage

FILE: rtl/core/tcpf_capture.sv
// Byte counter and header field capture for the drop filter.
// Depends on tcpf_pkg; feeds tcpf_verdict with captured fields and frame-end events.
`timescale 1ns / 1ps

module tcpf_capture
    import tcpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        evt_taken,
    output frame_evt_t  evt,
    output hdr_fields_t hdr
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             evt_valid_reg, evt_valid_next;
    logic [POS_W-1:0] evt_idx_reg;
    logic [31:0]      src_addr_reg;
    hdr_fields_t      hdr_reg;
    logic             in_xfer;
    logic [7:0]       src_byte;

    // Input is taken whenever the pending frame-end slot is free or draining
    assign s_ready = !evt_valid_reg || evt_taken;
    assign in_xfer = s_valid && s_ready;

    // Byte position: back to zero after the final byte, saturates otherwise
    always_comb begin
        pos_next = pos_reg;
        if (in_xfer) begin
            if (s_last_byte) begin
                pos_next = '0;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Frame-end event slot
    always_comb begin
        evt_valid_next = evt_valid_reg;
        if (in_xfer && s_last_byte) begin
            evt_valid_next = 1'b1;
        end else if (evt_taken) begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            evt_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_last_byte) begin
            evt_idx_reg <= pos_reg;
        end
    end

    // Source address byte matching the destination byte at this offset
    always_comb begin
        case (pos_reg)
            OFS_DST_0: src_byte = src_addr_reg[31:24];
            OFS_DST_1: src_byte = src_addr_reg[23:16];
            OFS_DST_2: src_byte = src_addr_reg[15:8];
            default:   src_byte = src_addr_reg[7:0];
        endcase
    end

    // Header field capture by byte offset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            case (pos_reg)
                OFS_ETYPE_HI, OFS_ETYPE_LO:
                    hdr_reg.ether_type <= {hdr_reg.ether_type[7:0], s_data_byte};
                OFS_FRAG_HI, OFS_FRAG_LO:
                    hdr_reg.fragment_field <= {hdr_reg.fragment_field[7:0], s_data_byte};
                OFS_PROTO:
                    hdr_reg.ip_protocol <= s_data_byte;
                OFS_SRC_0, OFS_SRC_1, OFS_SRC_2, OFS_SRC_3:
                    src_addr_reg <= {src_addr_reg[23:0], s_data_byte};
                OFS_DST_0:
                    hdr_reg.addresses_equal <= (src_byte == s_data_byte);
                OFS_DST_1, OFS_DST_2, OFS_DST_3:
                    hdr_reg.addresses_equal <= hdr_reg.addresses_equal
                                               && (src_byte == s_data_byte);
                OFS_ICMP_TYPE:
                    hdr_reg.icmp_kind <= s_data_byte;
                OFS_ICMP_CODE:
                    hdr_reg.icmp_subcode <= s_data_byte;
                OFS_TCP_DOFF:
                    hdr_reg.header_words <= s_data_byte[7:4];
                OFS_TCP_FLAGS:
                    hdr_reg.flag_bits <= s_data_byte[5:0];
                OFS_WIN_HI, OFS_WIN_LO:
                    hdr_reg.window_size <= {hdr_reg.window_size[7:0], s_data_byte};
                default: begin
                end
            endcase
        end
    end

    assign evt.valid    = evt_valid_reg;
    assign evt.last_idx = evt_idx_reg;
    assign hdr          = hdr_reg;

endmodule

FILE: rtl/core/tcpf_verdict.sv
// Rule evaluation, saturating TCP frame counter and result register.
// Depends on tcpf_pkg; consumes events and fields from tcpf_capture.
`timescale 1ns / 1ps

module tcpf_verdict
    import tcpf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  frame_evt_t       evt,
    input  hdr_fields_t      hdr,
    output logic             evt_taken,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_drop,
    output logic [CNT_W-1:0] m_tcp_packets
);

    logic             m_valid_reg, m_valid_next;
    logic             m_drop_reg;
    logic [CNT_W-1:0] m_tcp_packets_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_free;
    logic             ipv4_ok, tcp_full, icmp_full;
    logic             fin, syn, rst, psh, ack, urg;
    logic             tcp_bad, icmp_bad, drop_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign evt_taken = evt.valid && out_free;

    // Header completeness for each protocol
    assign ipv4_ok   = (evt.last_idx >= IDX_MIN_IPV4) && (hdr.ether_type == ETYPE_IPV4);
    assign tcp_full  = ipv4_ok && (hdr.ip_protocol == PROTO_TCP)
                       && (evt.last_idx >= IDX_MIN_TCP);
    assign icmp_full = ipv4_ok && (hdr.ip_protocol == PROTO_ICMP)
                       && (evt.last_idx >= IDX_MIN_ICMP);

    assign fin = hdr.flag_bits[FLAG_FIN];
    assign syn = hdr.flag_bits[FLAG_SYN];
    assign rst = hdr.flag_bits[FLAG_RST];
    assign psh = hdr.flag_bits[FLAG_PSH];
    assign ack = hdr.flag_bits[FLAG_ACK];
    assign urg = hdr.flag_bits[FLAG_URG];

    // TCP drop rules; data offset is 4 bits so it never exceeds 15
    assign tcp_bad = (syn && !ack) || (fin && !ack) || rst || (syn && fin) || (psh && urg)
                     || (hdr.flag_bits == '0) || (hdr.header_words < DOFF_MIN)
                     || (hdr.flag_bits == FLAGS_ACK_ONLY) || (syn && ack)
                     || (hdr.window_size == '0) || hdr.addresses_equal
                     || ((hdr.fragment_field & FRAG_MASK) != '0);

    // ICMP echo request or echo reply with code zero
    assign icmp_bad = ((hdr.icmp_kind == ICMP_ECHO_REQ) || (hdr.icmp_kind == ICMP_ECHO_REPLY))
                      && (hdr.icmp_subcode == ICMP_CODE_ZERO);

    assign drop_next = (tcp_full && tcp_bad) || (icmp_full && icmp_bad);

    // Saturating count of complete TCP frames
    always_comb begin
        count_next = count_reg;
        if (tcp_full && (count_reg != '1)) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (evt_taken) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (evt_taken) begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (evt_taken) begin
            m_drop_reg        <= drop_next;
            m_tcp_packets_reg <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drop        = m_drop_reg;
    assign m_tcp_packets = m_tcp_packets_reg;

endmodule

FILE: rtl/core/tcp_icmp_header_drop_filter_top.sv
// After the final byte of a frame is transferred, its end event is registered in the
// frame-end event slot; the verdict is registered once the result register is free.
// Throughput: one byte per cycle; the frame-end event slot and the result register
// let the next frame stream in while a verdict waits to be taken. Input stalls only
// when a second frame ends before the waiting verdict is taken.
// Reset (aresetn, synchronous, active low) clears the byte position, the pending
// event, the result valid and the TCP frame count; captured fields are not reset.
// Top level of the TCP/ICMP header drop filter; depends on tcpf_pkg,
// tcpf_capture and tcpf_verdict.
`timescale 1ns / 1ps

module tcp_icmp_header_drop_filter_top
    import tcpf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_drop,
    output logic [CNT_W-1:0] m_tcp_packets
);

    frame_evt_t  evt;
    hdr_fields_t hdr;
    logic        evt_taken;

    tcpf_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .evt_taken   (evt_taken),
        .evt         (evt),
        .hdr         (hdr)
    );

    tcpf_verdict u_verdict (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .evt           (evt),
        .hdr           (hdr),
        .evt_taken     (evt_taken),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drop        (m_drop),
        .m_tcp_packets (m_tcp_packets)
    );

endmodule

FILE: rtl/core/tcpf_checker.sv
// Port-level checks for the drop filter, bound to the top level.
// Depends on tcpf_pkg and tcp_icmp_header_drop_filter_top.
`timescale 1ns / 1ps

module tcpf_checker
    import tcpf_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_last_byte,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_drop,
    input logic [CNT_W-1:0] m_tcp_packets
);

    logic [CNT_W-1:0] last_count_reg;
    logic [CNT_W:0]   last_count_inc;

    // Count carried by the most recent result transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_count_reg <= m_tcp_packets;
        end
    end

    assign last_count_inc = {1'b0, last_count_reg} + 1'b1;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drop) && $stable(m_tcp_packets))
        else $error("result changed while stalled");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The TCP count never goes backward between results
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tcp_packets >= last_count_reg)
        else $error("TCP frame count decreased");

    // At most one TCP frame is counted per result
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_tcp_packets} <= last_count_inc)
        else $error("TCP frame count jumped by more than one");

    // A new result follows the transfer of a final byte through the event slot and result register
    a_no_result_before_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_byte, 2))
        else $error("result without a frame end");

endmodule

bind tcp_icmp_header_drop_filter_top tcpf_checker u_tcpf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_byte   (s_last_byte),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_drop        (m_drop),
    .m_tcp_packets (m_tcp_packets)
);

FILE: tb/tcp_icmp_header_drop_filter_top_test.sv
// Self-checking testbench for the TCP/ICMP header drop filter: streams whole frames
// byte by byte, predicts each verdict and TCP frame count, and checks every result.
// Depends on tcpf_pkg and tcp_icmp_header_drop_filter_top.
`timescale 1ns / 1ps

module tcp_icmp_header_drop_filter_top_test;
    import tcpf_pkg::*;

    localparam logic [5:0] M_FIN = 6'(1 << FLAG_FIN);
    localparam logic [5:0] M_SYN = 6'(1 << FLAG_SYN);
    localparam logic [5:0] M_RST = 6'(1 << FLAG_RST);
    localparam logic [5:0] M_PSH = 6'(1 << FLAG_PSH);
    localparam logic [5:0] M_ACK = 6'(1 << FLAG_ACK);
    localparam logic [5:0] M_URG = 6'(1 << FLAG_URG);

    localparam int DIRECTED_ROWS = 25;
    localparam int MAX_FRAME     = 128;
    localparam int STALL_CYCLES  = 400;
    localparam int TAIL_CYCLES   = 20;

    // Header content of one frame; everything else is random filler
    typedef struct {
        int          len;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] frag;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  icmp_t;
        logic [7:0]  icmp_c;
        logic [7:0]  doff_b;
        logic [7:0]  flags_b;
        logic [15:0] win;
    } frame_t;

    typedef struct packed {
        logic             drop;
        logic [CNT_W-1:0] count;
    } verdict_t;

    typedef struct packed {
        logic known;
        logic drop;
    } typed_drop_t;

    logic             aclk;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte   = 8'h00;
    logic             s_last_byte   = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic             m_drop;
    logic [CNT_W-1:0] m_tcp_packets;

    // Predicted filter state
    logic [POS_W-1:0] p_pos   = '0;
    logic [15:0]      p_etype = '0;
    logic [7:0]       p_proto = '0;
    logic [15:0]      p_frag  = '0;
    logic [31:0]      p_src   = '0;
    logic             p_eq    = 1'b0;
    logic [5:0]       p_flags = '0;
    logic [3:0]       p_doff  = '0;
    logic [15:0]      p_win   = '0;
    logic [7:0]       p_ikind = '0;
    logic [7:0]       p_icode = '0;
    logic [CNT_W-1:0] p_count = '0;

    verdict_t    pending_verdicts[$];
    typed_drop_t typed_drops[$];
    verdict_t    want;

    int errors        = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 75;
    int stall_req     = 0;
    int stall_seen    = 0;
    int stall_left    = 0;

    tcp_icmp_header_drop_filter_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drop        (m_drop),
        .m_tcp_packets (m_tcp_packets)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor: update captured fields for one byte, queue the verdict on the last
    task automatic track_filter_byte(input logic [7:0] b, input logic is_last);
        logic [POS_W-1:0] idx;
        logic [5:0]       fl;
        logic             same;
        logic             drop_v;
        typed_drop_t      td;
        int               sh;
        int               len;
        idx = p_pos;
        case (idx)
            OFS_ETYPE_HI, OFS_ETYPE_LO: p_etype = {p_etype[7:0], b};
            OFS_FRAG_HI, OFS_FRAG_LO:   p_frag = {p_frag[7:0], b};
            OFS_PROTO:                  p_proto = b;
            OFS_SRC_0, OFS_SRC_1, OFS_SRC_2, OFS_SRC_3: p_src = {p_src[23:0], b};
            OFS_DST_0, OFS_DST_1, OFS_DST_2, OFS_DST_3: begin
                sh = (int'(OFS_DST_3) - int'(idx)) * 8;
                same = (p_src[sh +: 8] == b);
                p_eq = (idx == OFS_DST_0) ? same : (p_eq & same);
            end
            OFS_ICMP_TYPE:              p_ikind = b;
            OFS_ICMP_CODE:              p_icode = b;
            OFS_TCP_DOFF:               p_doff = b[7:4];
            OFS_TCP_FLAGS:              p_flags = b[5:0];
            OFS_WIN_HI, OFS_WIN_LO:     p_win = {p_win[7:0], b};
            default: ;
        endcase
        if (!is_last) begin
            if (idx != POS_MAX) p_pos = idx + 1'b1;
        end else begin
            len = int'(idx) + 1;
            drop_v = 1'b0;
            fl = p_flags;
            if (len > int'(IDX_MIN_IPV4) && p_etype == ETYPE_IPV4) begin
                if (p_proto == PROTO_TCP) begin
                    if (len > int'(IDX_MIN_TCP)) begin
                        if (p_count != '1) p_count++;
                        drop_v = (fl[FLAG_SYN] && !fl[FLAG_ACK])
                              || (fl[FLAG_FIN] && !fl[FLAG_ACK])
                              || fl[FLAG_RST]
                              || (fl[FLAG_SYN] && fl[FLAG_FIN])
                              || (fl[FLAG_PSH] && fl[FLAG_URG])
                              || fl == 6'b0
                              || p_doff < DOFF_MIN
                              || fl == FLAGS_ACK_ONLY
                              || (fl[FLAG_SYN] && fl[FLAG_ACK])
                              || p_win == 16'h0
                              || p_eq
                              || (p_frag & FRAG_MASK) != 16'h0;
                    end
                end else if (p_proto == PROTO_ICMP && len > int'(IDX_MIN_ICMP)) begin
                    drop_v = (p_ikind == ICMP_ECHO_REQ || p_ikind == ICMP_ECHO_REPLY)
                          && p_icode == ICMP_CODE_ZERO;
                end
            end
            // a directed row may carry its verdict typed in
            if (typed_drops.size() != 0) begin
                td = typed_drops.pop_front();
                if (td.known) drop_v = td.drop;
            end
            pending_verdicts.push_back('{drop_v, p_count});
            p_pos = '0;
        end
    endtask

    // Track accepted bytes and check result transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) track_filter_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result: drop=%0d tcp_packets=%0d",
                             $time, m_drop, m_tcp_packets);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_drop !== want.drop) begin
                        $display("%0t: drop mismatch: expected %0d, actual %0d",
                                 $time, want.drop, m_drop);
                        errors++;
                    end
                    if (m_tcp_packets !== want.count) begin
                        $display("%0t: tcp_packets mismatch: expected %0d, actual %0d",
                                 $time, want.count, m_tcp_packets);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: random backpressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= STALL_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one byte, with random idle cycles first; returns at its transfer
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_frame(input frame_t f, input logic known, input logic drop_v);
        logic [7:0] fb [MAX_FRAME];
        int i;
        for (i = 0; i < MAX_FRAME; i++) fb[i] = 8'($urandom);
        fb[OFS_ETYPE_HI]  = f.etype[15:8];
        fb[OFS_ETYPE_LO]  = f.etype[7:0];
        fb[OFS_FRAG_HI]   = f.frag[15:8];
        fb[OFS_FRAG_LO]   = f.frag[7:0];
        fb[OFS_PROTO]     = f.proto;
        fb[OFS_SRC_0]     = f.src[31:24];
        fb[OFS_SRC_1]     = f.src[23:16];
        fb[OFS_SRC_2]     = f.src[15:8];
        fb[OFS_SRC_3]     = f.src[7:0];
        fb[OFS_DST_0]     = f.dst[31:24];
        fb[OFS_DST_1]     = f.dst[23:16];
        fb[OFS_DST_2]     = f.dst[15:8];
        fb[OFS_DST_3]     = f.dst[7:0];
        fb[OFS_ICMP_TYPE] = f.icmp_t;
        fb[OFS_ICMP_CODE] = f.icmp_c;
        fb[OFS_TCP_DOFF]  = f.doff_b;
        fb[OFS_TCP_FLAGS] = f.flags_b;
        fb[OFS_WIN_HI]    = f.win[15:8];
        fb[OFS_WIN_LO]    = f.win[7:0];
        typed_drops.push_back('{known, drop_v});
        for (i = 0; i < f.len; i++) send_byte(fb[i], i == f.len - 1);
    endtask

    // A TCP frame that passes every rule, with random content
    function automatic frame_t good_tcp();
        frame_t     f;
        logic [5:0] fl;
        f.len    = $urandom_range(54, 56);
        f.etype  = ETYPE_IPV4;
        f.proto  = PROTO_TCP;
        f.frag   = {2'($urandom), 14'd0};
        f.src    = $urandom;
        do f.dst = $urandom; while (f.dst == f.src);
        f.icmp_t = 8'($urandom);
        f.icmp_c = 8'($urandom);
        f.doff_b = {4'($urandom_range(5, 15)), 4'($urandom)};
        case ($urandom_range(0, 4))
            0: fl = M_ACK | M_PSH;
            1: fl = M_ACK | M_FIN;
            2: fl = M_ACK | M_URG;
            3: fl = M_ACK | M_PSH | M_FIN;
            default: fl = M_ACK | M_URG | M_FIN;
        endcase
        f.flags_b = {2'($urandom), fl};
        f.win     = 16'($urandom_range(1, 65535));
        return f;
    endfunction

    // Directed rows: each starts from a passing TCP frame and changes its fields or length
    task automatic directed_row(input int i, output frame_t f, output logic known,
                                output logic drop_v);
        f = good_tcp();
        known = 1'b1;
        drop_v = 1'b1;
        case (i)
            0:  begin f.len = 1;  drop_v = 1'b0; end  // lone byte right after reset
            1:  begin f.len = 13; drop_v = 1'b0; end  // ethertype incomplete
            2:  begin f.etype = 16'h86DD; f.len = 64; drop_v = 1'b0; end
            3:  begin f.len = 33; drop_v = 1'b0; end  // IPv4 header one byte short
            4:  begin f.len = 53; f.flags_b = 8'(M_SYN); drop_v = 1'b0; end
            5:  begin f.len = 54; f.flags_b = 8'(M_ACK | M_PSH); drop_v = 1'b0; end
            6:  f.flags_b = 8'(M_SYN);
            7:  f.flags_b = 8'(M_FIN);
            8:  f.flags_b = 8'(M_RST | M_ACK);
            9:  f.flags_b = 8'(M_SYN | M_FIN | M_ACK);
            10: f.flags_b = 8'(M_PSH | M_URG | M_ACK);
            11: f.flags_b = 8'hC0;                    // null scan, reserved bits set
            12: f.doff_b = 8'h4F;
            13: f.flags_b = 8'(M_ACK);
            14: f.flags_b = 8'(M_SYN | M_ACK);
            15: f.win = 16'h0000;
            16: f.dst = f.src;
            17: f.frag = 16'h2000;                    // more-fragments bit
            18: begin                                 // long frame, top frag bits only
                f.len = 70; f.frag = 16'hC000; f.doff_b = 8'hF0;
                f.win = 16'hFFFF; drop_v = 1'b0;
            end
            19: f.frag = 16'h0001;
            20: begin f.proto = PROTO_ICMP; f.len = 42;
                f.icmp_t = ICMP_ECHO_REQ; f.icmp_c = ICMP_CODE_ZERO; end
            21: begin f.proto = PROTO_ICMP; f.len = 64;
                f.icmp_t = ICMP_ECHO_REPLY; f.icmp_c = ICMP_CODE_ZERO; end
            22: begin f.proto = PROTO_ICMP; f.len = 50; drop_v = 1'b0;
                f.icmp_t = ICMP_ECHO_REQ; f.icmp_c = 8'd1; end
            23: begin f.proto = PROTO_ICMP; f.len = 41; drop_v = 1'b0;
                f.icmp_t = ICMP_ECHO_REQ; f.icmp_c = ICMP_CODE_ZERO; end
            default: begin f.proto = 8'd17; f.len = 64; drop_v = 1'b0; end
        endcase
    endtask

    // Random frame: mostly well-formed TCP and ICMP, some short, some not IPv4
    function automatic frame_t rand_frame();
        frame_t f;
        int     r;
        int     lr;
        f = good_tcp();
        r = $urandom_range(0, 99);
        lr = $urandom_range(0, 99);
        if (r < 55) begin
            if ($urandom_range(0, 9) == 0) f.flags_b = 8'($urandom);
            if ($urandom_range(0, 9) == 0) f.doff_b = {4'($urandom_range(0, 4)), 4'($urandom)};
            if ($urandom_range(0, 9) == 0) f.win = 16'h0000;
            if ($urandom_range(0, 11) == 0) f.dst = f.src;
            if ($urandom_range(0, 11) == 0) f.dst = f.src ^ (32'hFF << (8 * $urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0) f.frag = 16'($urandom);
            if (lr < 15) f.len = $urandom_range(65, 120);
            else if (lr < 25) f.len = $urandom_range(34, 53);
        end else if (r < 75) begin
            f.proto = PROTO_ICMP;
            case ($urandom_range(0, 3))
                0: f.icmp_t = ICMP_ECHO_REQ;
                1: f.icmp_t = ICMP_ECHO_REPLY;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 0) f.icmp_c = ICMP_CODE_ZERO;
            f.len = (lr < 20) ? $urandom_range(34, 41) : $urandom_range(42, 70);
        end else if (r < 85) begin
            f.proto = 8'($urandom);
            f.len = $urandom_range(34, 64);
        end else if (r < 93) begin
            f.len = $urandom_range(1, 33);
        end else begin
            case ($urandom_range(0, 3))
                0: f.etype = 16'h0801;
                1: f.etype = 16'h0008;
                2: f.etype = 16'h8800;
                default: f.etype = 16'($urandom);
            endcase
            f.len = $urandom_range(1, 80);
        end
        return f;
    endfunction

    task automatic run_random(input int min_frames, input int min_bytes);
        frame_t f;
        int     frames;
        int     bytes;
        frames = 0;
        bytes = 0;
        while (frames < min_frames || bytes < min_bytes) begin
            f = rand_frame();
            send_frame(f, 1'b0, 1'b0);
            frames++;
            bytes += f.len;
        end
    endtask

    // Sender pauses until every queued verdict has been transferred
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    initial begin
        frame_t f;
        logic   known;
        logic   drop_v;
        int     i;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            directed_row(i, f, known, drop_v);
            send_frame(f, known, drop_v);
        end
        run_random(3, 120);
        drain();

        // roles swapped
        send_idle_pct = 75;
        recv_idle_pct = 23;
        run_random(3, 120);
        drain();

        // full rate, opening with a long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req <= stall_req + 1;
        run_random(3, 120);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // Run-time limit
    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
